// ----- design/ppp_pkg.sv -----
// Shared types, constants and the divider step of the pinhole point projector.
`timescale 1ns / 1ps
package ppp_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int DIV_BITS    = 32;
	localparam int DIV_PER_STG = 2;
	localparam int DIV_STAGES  = DIV_BITS / DIV_PER_STG;

	localparam logic [DATA_W-1:0] ONE_FIXED = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN   = 32'h8000_0000;

	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_SKEW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd4;

	typedef struct packed {
		logic [63:0] fx;
		logic [63:0] sk;
		logic [63:0] cx;
		logic [63:0] fy;
		logic [63:0] cy;
		logic [31:0] z;
	} prod_t;

	typedef struct packed {
		logic [30:0] rem;
		logic [31:0] bits;
		logic        neg;
		logic        ovf;
	} div_lane_t;

	typedef struct packed {
		logic [30:0] z;
		div_lane_t   u;
		div_lane_t   v;
		logic        front;
	} div_item_t;

	function automatic div_lane_t div_step(div_lane_t l, logic [30:0] z);
		div_lane_t   r;
		logic [31:0] t;
		logic        q;
		r = l;
		t = {l.rem, l.bits[31]};
		q = (t >= {1'b0, z});
		r.rem = q ? 31'(t - {1'b0, z}) : t[30:0];
		r.bits = {l.bits[30:0], q};
		return r;
	endfunction

endpackage

// ----- design/ppp_if.sv -----
// Point and pixel channel interfaces.
`timescale 1ns / 1ps
interface ppp_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_coord;
	logic [31:0] y_coord;
	logic [31:0] z_depth;
	modport source (output valid, x_coord, y_coord, z_depth, input ready);
	modport sink (input valid, x_coord, y_coord, z_depth, output ready);
endinterface

interface ppp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_u;
	logic [31:0] pixel_v;
	logic        in_front;
	logic        overflow;
	modport source (output valid, pixel_u, pixel_v, in_front, overflow, input ready);
	modport sink (input valid, pixel_u, pixel_v, in_front, overflow, output ready);
endinterface

// ----- design/pinhole_point_projection_top.sv -----
// Top level of the pinhole point projector.
//
// channel   dir  handshake     payload
// pt_in     in   valid/ready   x_coord, y_coord, z_depth (Q16.16)
// px_out    out  valid/ready   pixel_u, pixel_v (Q16.16), in_front, overflow
// cfg       in   cfg_we        cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the stages are product, sum, magnitude, range check,
// 16 divider stages of two quotient bits each, output register.
// The divider chain sets the latency; the rate is one item every cycle while no stall holds it.
// Reset clears the valid bits and loads the intrinsic registers.
// A stall at the output holds every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
module pinhole_point_projection_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppp_pkg::DATA_W-1:0]      cfg_data,
	ppp_in_if.sink                          pt_in,
	ppp_out_if.source                       px_out
);
	import ppp_pkg::*;

	logic [31:0] focal_x_q, focal_y_q, axis_skew_q, center_x_q, center_y_q;
	logic        en;

	prod_t       prod_s1;
	logic        valid_s1;
	logic [65:0] sum_u_s2, sum_v_s2;
	logic [31:0] z_s2;
	logic        front_s2, valid_s2;
	logic [63:0] mag_u_s3, mag_v_s3;
	logic        neg_u_s3, neg_v_s3, front_s3, valid_s3;
	logic [30:0] z_s3;
	div_item_t   item_s4;
	logic        valid_s4;

	div_item_t   div_item [DIV_STAGES+1];
	logic        div_valid [DIV_STAGES+1];

	div_item_t   fin;
	logic [31:0] u_val, v_val;
	logic        out_valid_q;
	logic [31:0] pixel_u_q, pixel_v_q;
	logic        in_front_q, overflow_q;

	assign en          = !out_valid_q || px_out.ready;
	assign pt_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q   <= ONE_FIXED;
			focal_y_q   <= ONE_FIXED;
			axis_skew_q <= '0;
			center_x_q  <= '0;
			center_y_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOCAL_X:   focal_x_q   <= cfg_data;
				REG_FOCAL_Y:   focal_y_q   <= cfg_data;
				REG_AXIS_SKEW: axis_skew_q <= cfg_data;
				REG_CENTER_X:  center_x_q  <= cfg_data;
				REG_CENTER_Y:  center_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ppp_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (pt_in.valid),
		.focal_x   (focal_x_q),
		.focal_y   (focal_y_q),
		.axis_skew (axis_skew_q),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.x_coord   (pt_in.x_coord),
		.y_coord   (pt_in.y_coord),
		.z_depth   (pt_in.z_depth),
		.prod_s1   (prod_s1),
		.valid_s1  (valid_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_u_s2 <= 66'($signed(prod_s1.fx)) + 66'($signed(prod_s1.sk))
				+ 66'($signed(prod_s1.cx));
			sum_v_s2 <= 66'($signed(prod_s1.fy)) + 66'($signed(prod_s1.cy));
			z_s2     <= prod_s1.z;
			front_s2 <= !prod_s1.z[31] && (|prod_s1.z[30:0]);

			neg_u_s3 <= sum_u_s2[65];
			neg_v_s3 <= sum_v_s2[65];
			mag_u_s3 <= sum_u_s2[65] ? 64'(-sum_u_s2) : sum_u_s2[63:0];
			mag_v_s3 <= sum_v_s2[65] ? 64'(-sum_v_s2) : sum_v_s2[63:0];
			z_s3     <= z_s2[30:0];
			front_s3 <= front_s2;

			item_s4.z        <= z_s3;
			item_s4.front    <= front_s3;
			item_s4.u.neg    <= neg_u_s3;
			item_s4.u.rem    <= mag_u_s3[62:32];
			item_s4.u.bits   <= mag_u_s3[31:0];
			item_s4.u.ovf    <= neg_u_s3 ? (mag_u_s3 >= {2'b00, z_s3, z_s3})
				: (mag_u_s3 >= {2'b00, z_s3, 31'd0});
			item_s4.v.neg    <= neg_v_s3;
			item_s4.v.rem    <= mag_v_s3[62:32];
			item_s4.v.bits   <= mag_v_s3[31:0];
			item_s4.v.ovf    <= neg_v_s3 ? (mag_v_s3 >= {2'b00, z_s3, z_s3})
				: (mag_v_s3 >= {2'b00, z_s3, 31'd0});
		end
	end

	assign div_item[0]  = item_s4;
	assign div_valid[0] = valid_s4;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		ppp_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid    (div_valid[g]),
			.item     (div_item[g]),
			.item_sd  (div_item[g+1]),
			.valid_sd (div_valid[g+1])
		);
	end

	assign fin = div_item[DIV_STAGES];

	always_comb begin
		if (fin.u.ovf) begin
			u_val = fin.u.neg ? SAT_MIN : SAT_MAX;
		end else begin
			u_val = fin.u.neg ? 32'(-fin.u.bits) : fin.u.bits;
		end
		if (fin.v.ovf) begin
			v_val = fin.v.neg ? SAT_MIN : SAT_MAX;
		end else begin
			v_val = fin.v.neg ? 32'(-fin.v.bits) : fin.v.bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_u_q  <= fin.front ? u_val : '0;
			pixel_v_q  <= fin.front ? v_val : '0;
			in_front_q <= fin.front;
			overflow_q <= fin.front && (fin.u.ovf || fin.v.ovf);
		end
	end

	assign px_out.valid    = out_valid_q;
	assign px_out.pixel_u  = pixel_u_q;
	assign px_out.pixel_v  = pixel_v_q;
	assign px_out.in_front = in_front_q;
	assign px_out.overflow = overflow_q;

	a_ovf_front: assert property (@(posedge clk) disable iff (!arst_n)
		(px_out.valid && px_out.overflow) |-> px_out.in_front)
		else $error("overflow without in_front");

	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(px_out.valid && !px_out.in_front) |-> (px_out.pixel_u == '0 && px_out.pixel_v == '0))
		else $error("point behind camera gave nonzero pixel");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(px_out.valid && px_out.overflow) |-> (px_out.pixel_u == SAT_MAX
		|| px_out.pixel_u == SAT_MIN || px_out.pixel_v == SAT_MAX
		|| px_out.pixel_v == SAT_MIN))
		else $error("overflow flagged without a saturated coordinate");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_in.valid && pt_in.ready) |=> valid_s1)
		else $error("accepted item lost at first stage");

endmodule

// ----- design/ppp_mult.sv -----
// First pipeline stage: the five intrinsic products.
`timescale 1ns / 1ps
module ppp_mult (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid,
	input  logic [31:0]   focal_x,
	input  logic [31:0]   focal_y,
	input  logic [31:0]   axis_skew,
	input  logic [31:0]   center_x,
	input  logic [31:0]   center_y,
	input  logic [31:0]   x_coord,
	input  logic [31:0]   y_coord,
	input  logic [31:0]   z_depth,
	output ppp_pkg::prod_t prod_s1,
	output logic          valid_s1
);
	import ppp_pkg::*;

	logic signed [63:0] fx, sk, cx, fy, cy;

	always_comb begin
		fx = $signed(focal_x) * $signed(x_coord);
		sk = $signed(axis_skew) * $signed(y_coord);
		cx = $signed(center_x) * $signed(z_depth);
		fy = $signed(focal_y) * $signed(y_coord);
		cy = $signed(center_y) * $signed(z_depth);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.fx <= fx;
			prod_s1.sk <= sk;
			prod_s1.cx <= cx;
			prod_s1.fy <= fy;
			prod_s1.cy <= cy;
			prod_s1.z  <= z_depth;
		end
	end

endmodule

// ----- design/ppp_div_stage.sv -----
// One divider stage: two quotient bits for both coordinates.
`timescale 1ns / 1ps
module ppp_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid,
	input  ppp_pkg::div_item_t  item,
	output ppp_pkg::div_item_t  item_sd,
	output logic                valid_sd
);
	import ppp_pkg::*;

	div_item_t nxt;

	always_comb begin
		nxt = item;
		for (int i = 0; i < DIV_PER_STG; i++) begin
			nxt.u = div_step(nxt.u, item.z);
			nxt.v = div_step(nxt.v, item.z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (en) begin
			valid_sd <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_sd <= nxt;
		end
	end

endmodule
